[hdl/bstr_pkg.sv]
// ----------------------------------------------------------------------------
// bstr_pkg
// Types and constants shared by the sorted time ranking block.
// ----------------------------------------------------------------------------
package bstr_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 14;
    localparam int CNT_W = 5;

    typedef logic [KEY_W-1:0] bstr_key_t;
    typedef logic [CNT_W-1:0] bstr_cnt_t;

    typedef struct packed {
        logic [7:0] finish_minutes;
        logic [5:0] finish_seconds;
    } bstr_req_t;

    typedef struct packed {
        logic [4:0] rank_position;
        logic       was_stored;
        logic [4:0] entries_held;
    } bstr_res_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic en;
        logic any_eq;
        logic valid;
        logic tail;
    } bstr_cell_ctl_t;

    // Per-cell status back to the top level.
    typedef struct packed {
        logic gt;
        logic eq;
    } bstr_cell_sts_t;

    // minutes*60 + seconds, as (m<<6) - (m<<2) + s.
    function automatic bstr_key_t bstr_make_key(bstr_req_t req);
        bstr_key_t m64;
        bstr_key_t m4;
        m64 = {req.finish_minutes, 6'b0};
        m4  = {4'b0, req.finish_minutes, 2'b0};
        return m64 - m4 + {8'b0, req.finish_seconds};
    endfunction

endpackage

[hdl/bstr_cell.sv]
// ----------------------------------------------------------------------------
// bstr_cell
// One slot of the ranking list: holds a key, compares it with the new key,
// and takes either its upper neighbor's key or the new key on an insert.
// ----------------------------------------------------------------------------
module bstr_cell (
    input  logic                    clk,
    input  bstr_pkg::bstr_cell_ctl_t ctl,
    input  bstr_pkg::bstr_key_t     new_key,
    input  bstr_pkg::bstr_key_t     prev_key,
    input  logic                    prev_gt,
    output bstr_pkg::bstr_key_t     key,
    output bstr_pkg::bstr_cell_sts_t sts
);
    import bstr_pkg::*;

    bstr_key_t key_reg;
    bstr_key_t key_next;

    assign key    = key_reg;
    assign sts.gt = ctl.valid && (new_key < key_reg);
    assign sts.eq = ctl.valid && (new_key == key_reg);

    always_comb
    begin
        key_next = key_reg;
        if (ctl.en && !ctl.any_eq)
        begin
            if (prev_gt)
            begin
                key_next = prev_key;
            end
            else if (sts.gt || ctl.tail)
            begin
                key_next = new_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

[hdl/bounded_sorted_time_ranking.sv]
// ----------------------------------------------------------------------------
// bounded_sorted_time_ranking
// Ascending list of the best finish times, kept in a row of compare-and-shift
// cells; reports the rank of each new time and whether it was stored.
// ----------------------------------------------------------------------------
//  channel  | ports                  | handshake
//  ---------+------------------------+--------------------------------------
//  request  | start, busy, request   | taken when start is high, busy low
//  result   | done, result           | one-cycle strobe, cannot be held off
//
// A request is registered on the edge that takes it; on the next edge every
// cell compares and shifts at once, and the result and done are registered.
// A new request is taken every cycle, and busy stays low. Reset empties the
// list; stored keys are not cleared.
module bounded_sorted_time_ranking (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bstr_pkg::bstr_req_t request,
    output logic                done,
    output bstr_pkg::bstr_res_t result
);
    import bstr_pkg::*;

    bstr_key_t key_reg;
    logic      pend_reg;
    bstr_cnt_t count_reg;
    bstr_cnt_t count_next;
    bstr_res_t res_reg;
    bstr_res_t res_next;
    logic      done_reg;

    bstr_key_t      cell_key [DEPTH];
    bstr_cell_sts_t cell_sts [DEPTH];
    bstr_cell_ctl_t cell_ctl [DEPTH];
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] bound;
    logic [DEPTH-1:0] eq_vec;
    logic      any_eq;
    bstr_cnt_t pos;
    logic      stored;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            eq_vec[i] = cell_sts[i].eq;
            ge[i]     = cell_sts[i].gt || cell_sts[i].eq;
        end
    end

    assign any_eq = |eq_vec;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctl[i].en     = pend_reg;
            cell_ctl[i].any_eq = any_eq;
            cell_ctl[i].valid  = CNT_W'(i) < count_reg;
            cell_ctl[i].tail   = CNT_W'(i) == count_reg;
        end
    end

    // The list is ascending, so the entries at or above the new key form a
    // suffix of the valid ones; its first cell is the insert position.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                bound[i] = ge[i];
            end
            else
            begin
                bound[i] = ge[i] && !ge[i-1];
            end
            pos = pos | (bound[i] ? CNT_W'(i) : '0);
        end
        if (bound == '0)
        begin
            pos = count_reg;
        end
    end

    assign stored = !any_eq && (pos < CNT_W'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (pend_reg && stored && (count_reg < CNT_W'(DEPTH)))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        res_next.rank_position = pos + CNT_W'(1);
        res_next.was_stored    = stored;
        res_next.entries_held  = count_next;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            bstr_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[g]),
                .new_key  (key_reg),
                .prev_key (key_reg),
                .prev_gt  (1'b0),
                .key      (cell_key[g]),
                .sts      (cell_sts[g])
            );
        end
        else
        begin : g_rest
            bstr_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[g]),
                .new_key  (key_reg),
                .prev_key (cell_key[g-1]),
                .prev_gt  (cell_sts[g-1].gt),
                .key      (cell_key[g]),
                .sts      (cell_sts[g])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            pend_reg  <= start && !busy;
            done_reg  <= pend_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            key_reg <= bstr_make_key(request);
        end
        if (pend_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[hdl/bstr_checker.sv]
// ----------------------------------------------------------------------------
// bstr_checker
// Port-level checks on the ranking block, bound to the top level.
// ----------------------------------------------------------------------------
module bstr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input bstr_pkg::bstr_res_t result
);
    import bstr_pkg::*;

    // Every taken request yields its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("request without result");

    // No result appears without a request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without request");

    // The rank lies between one and one past the entry count.
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.rank_position != 5'd0)
              && (result.rank_position <= result.entries_held + 5'd1)
              && (result.entries_held <= 5'(DEPTH)))
        else $error("rank out of range");

    // A stored time leaves the list non-empty.
    a_stored_held: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.was_stored) |-> (result.entries_held != 5'd0))
        else $error("stored time in empty list");

endmodule

bind bounded_sorted_time_ranking bstr_checker u_bstr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[tb/bounded_sorted_time_ranking_tb.sv]
// ----------------------------------------------------------------------------
// bounded_sorted_time_ranking_tb
// Drives finish times into the ranking block and checks every result field
// against a behavioral copy of the sorted list. A short hand-written table
// covers the empty list, equal times, out-of-range seconds, a full list and
// the drop of its last entry. Random traffic then mostly falls at or under the
// stored times so that equal hits and insertions stay frequent.
// ----------------------------------------------------------------------------
module bounded_sorted_time_ranking_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bstr_pkg::*;

    localparam int RANDOM_REQUESTS = 700;
    localparam int PLAN_ROWS       = 23;
    localparam int MAX_KEY         = 255 * 60 + 63;

    typedef struct packed {
        bstr_req_t req;
        logic      fixed;
        bstr_res_t want;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    bstr_req_t request;
    logic      done;
    bstr_res_t result;

    int        board_keys [DEPTH];
    int        board_count;
    bstr_res_t pending_ranks [$];
    int        mismatch_count;
    plan_row_t plan [PLAN_ROWS];

    bounded_sorted_time_ranking DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Ranks one time against the list and updates the list as the block does.
    function automatic bstr_res_t rank_time(bstr_req_t req);
        int        key;
        int        pos;
        bit        hit;
        bstr_res_t res;
        key = (int'(req.finish_minutes) * 60 + int'(req.finish_seconds)) & 16'h3FFF;
        pos = board_count;
        hit = 1'b0;
        for (int j = 0; j < board_count; j++)
        begin
            if (board_keys[j] >= key)
            begin
                hit = (board_keys[j] == key);
                pos = j;
                break;
            end
        end
        res.was_stored = 1'b0;
        if (hit)
            res.rank_position = 5'(pos + 1);
        else if (pos >= DEPTH)
            res.rank_position = 5'(DEPTH + 1);
        else
        begin
            for (int k = ((board_count < DEPTH) ? board_count : DEPTH - 1); k > pos; k--)
                board_keys[k] = board_keys[k - 1];
            board_keys[pos] = key;
            if (board_count < DEPTH)
                board_count++;
            res.rank_position = 5'(pos + 1);
            res.was_stored = 1'b1;
        end
        res.entries_held = 5'(board_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(bstr_req_t req, bit fixed, bstr_res_t want);
        bstr_res_t predicted;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = rank_time(req);
        pending_ranks.push_back(fixed ? want : predicted);
    endtask

    // Start is lowered and the request bus carries junk while idle.
    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= bstr_req_t'($urandom);
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_ranks.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        bstr_res_t want;
        if (rst_n && done)
        begin
            if (pending_ranks.size() == 0)
            begin
                report_mismatch("outstanding requests", 0, 1);
            end
            else
            begin
                want = pending_ranks.pop_front();
                if (result.rank_position !== want.rank_position)
                    report_mismatch("rank_position", result.rank_position, want.rank_position);
                if (result.was_stored !== want.was_stored)
                    report_mismatch("was_stored", result.was_stored, want.was_stored);
                if (result.entries_held !== want.entries_held)
                    report_mismatch("entries_held", result.entries_held, want.entries_held);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("bounded_sorted_time_ranking_tb NOT OK");
        $finish;
    end

    initial
    begin
        int        key;
        int        mode;
        int        mins;
        int        gap;
        bit        burst;
        bstr_req_t req;

        start          = 1'b0;
        request        = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        board_count    = 0;
        for (int i = 0; i < DEPTH; i++)
            board_keys[i] = 0;

        // minutes, seconds, fixed, rank, stored, held
        plan = '{
            {8'd0,   6'd0,  1'b1, 5'd1,  1'b1, 5'd1},
            {8'd0,   6'd0,  1'b1, 5'd1,  1'b0, 5'd1},
            {8'd255, 6'd63, 1'b1, 5'd2,  1'b1, 5'd2},
            {8'd255, 6'd59, 1'b0, 11'd0},
            {8'd0,   6'd60, 1'b0, 11'd0},
            {8'd1,   6'd0,  1'b0, 11'd0},
            {8'd10,  6'd30, 1'b0, 11'd0},
            {8'd11,  6'd30, 1'b0, 11'd0},
            {8'd12,  6'd30, 1'b0, 11'd0},
            {8'd13,  6'd30, 1'b0, 11'd0},
            {8'd14,  6'd30, 1'b0, 11'd0},
            {8'd15,  6'd30, 1'b0, 11'd0},
            {8'd16,  6'd30, 1'b0, 11'd0},
            {8'd17,  6'd30, 1'b0, 11'd0},
            {8'd18,  6'd30, 1'b0, 11'd0},
            {8'd19,  6'd30, 1'b0, 11'd0},
            {8'd20,  6'd30, 1'b0, 11'd0},
            {8'd21,  6'd30, 1'b0, 11'd0},
            {8'd255, 6'd63, 1'b0, 11'd0},
            {8'd255, 6'd62, 1'b0, 11'd0},
            {8'd255, 6'd63, 1'b1, 5'd17, 1'b0, 5'd16},
            {8'd0,   6'd1,  1'b0, 11'd0},
            {8'd0,   6'd63, 1'b0, 11'd0}
        };

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            send_request(plan[i].req, plan[i].fixed, plan[i].want);
            idle_cycles((i % 3 == 2) ? $urandom_range(1, 4) : 0);
        end
        idle_cycles(1);
        wait_drained();

        burst = 1'b0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // Mostly times equal to a stored one or no later than the last stored one, so that the
            // full list keeps changing instead of rejecting everything.
            mode = $urandom_range(0, 9);
            if (mode < 3)
                key = board_keys[$urandom_range(0, board_count - 1)];
            else if (mode < 6)
                key = $urandom_range(0, board_keys[board_count - 1]);
            else
                key = $urandom_range(0, MAX_KEY);
            mins = key / 60;
            if (mins > 255)
                mins = 255;
            if (mins > 0 && key - mins * 60 < 4 && $urandom_range(0, 1) == 1)
                mins--;
            req.finish_minutes = 8'(mins);
            req.finish_seconds = 6'(key - mins * 60);
            send_request(req, 1'b0, '0);

            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_REQUESTS / 2)
            begin
                idle_cycles(1);
                wait_drained();
                idle_cycles($urandom_range(1, 5));
            end
            else if (!burst)
            begin
                gap = $urandom_range(0, 9);
                if (gap < 6)
                    idle_cycles(0);
                else if (gap < 9)
                    idle_cycles($urandom_range(1, 3));
                else
                    idle_cycles($urandom_range(10, 40));
            end
        end
        idle_cycles(1);
        wait_drained();
        repeat (6)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("bounded_sorted_time_ranking_tb OK");
        else
            $display("bounded_sorted_time_ranking_tb NOT OK");
        $finish;
    end

endmodule
